// File: hw/rtl/gru_pkg.sv
package gru_pkg;

	localparam int DATA_WIDTH_DEF     = 32;
	localparam int COEF_FRAC_BITS_DEF = 16;

endpackage

// File: hw/rtl/gru_req_if.sv
interface gru_req_if #(
	parameter int DATA_WIDTH     = gru_pkg::DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = gru_pkg::COEF_FRAC_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic                             req_type;
	logic signed [DATA_WIDTH-1:0]     x_in;
	logic signed [DATA_WIDTH-1:0]     y_in;
	logic signed [COEF_FRAC_BITS+1:0] cos_in;
	logic signed [COEF_FRAC_BITS+1:0] sin_in;

	modport source (output valid, req_type, x_in, y_in, cos_in, sin_in, input ready);
	modport sink (input valid, req_type, x_in, y_in, cos_in, sin_in, output ready);
endinterface

// File: hw/rtl/gru_rsp_if.sv
interface gru_rsp_if #(
	parameter int DATA_WIDTH     = gru_pkg::DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = gru_pkg::COEF_FRAC_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	logic signed [DATA_WIDTH-1:0]     x_out;
	logic signed [DATA_WIDTH-1:0]     y_out;
	logic signed [COEF_FRAC_BITS+1:0] cos_out;
	logic signed [COEF_FRAC_BITS+1:0] sin_out;
	logic                             saturated;

	modport source (output valid, x_out, y_out, cos_out, sin_out, saturated, input ready);
	modport sink (input valid, x_out, y_out, cos_out, sin_out, saturated, output ready);
endinterface

// File: hw/rtl/gru_div_cell.sv
module gru_div_cell #(
	parameter int RW  = 49,
	parameter int DVW = 32,
	parameter int QW  = 17,
	parameter int SH  = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW-1:0] rem_i,
	input  logic [DVW-1:0] dvs_i,
	input  logic [QW-1:0] quo_i,
	output logic [RW-1:0] rem_o,
	output logic [DVW-1:0] dvs_o,
	output logic [QW-1:0] quo_o
);
	logic [RW-1:0] dvs_sh;
	logic          ge;

	assign dvs_sh = {{(RW-DVW){1'b0}}, dvs_i} << SH;
	assign ge     = rem_i >= dvs_sh;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? (rem_i - dvs_sh) : rem_i;
			dvs_o <= dvs_i;
			quo_o <= {quo_i[QW-2:0], ge};
		end
	end
endmodule

// File: hw/rtl/gru_sqrt_cell.sv
module gru_sqrt_cell #(
	parameter int UW = 34,
	parameter int J  = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [UW-1:0] rem_i,
	input  logic [UW-1:0] res_i,
	output logic [UW-1:0] rem_o,
	output logic [UW-1:0] res_o
);
	localparam logic [UW-1:0] BIT = {{(UW-1){1'b0}}, 1'b1} << (2 * J);

	logic [UW-1:0] trial;
	logic          ge;

	assign trial = res_i + BIT;
	assign ge    = rem_i >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? (rem_i - trial) : rem_i;
			res_o <= ge ? ((res_i >> 1) + BIT) : (res_i >> 1);
		end
	end
endmodule

// File: hw/rtl/givens_rotation_unit_core.sv
// Givens rotation unit.
// Requests enter on req (valid/ready): req_type 0 derives cos and sin from
// (x_in, y_in) and rotates the pair; req_type 1 rotates with cos_in/sin_in.
// Results leave on rsp (valid/ready): rotated pair, cos, sin, saturated flag.
// The datapath is a row of 3*COEF_FRAC_BITS+9 register cells: an input cell,
// one quotient bit per cell for the ratio, a cell that squares the ratio,
// one root bit per cell for the square root, a cell that sets up the
// reciprocal, one quotient bit per cell for the reciprocal, then the
// coefficient select, the four rotation products and the round/saturate
// output stage.
// Throughput is one request per cycle while the receiver keeps rsp.ready high.
// Each cell advances when it is empty or its successor advances, so while the
// receiver stalls the output holds and empty cells upstream keep filling;
// ready drops only when every cell is full.
// Reset clears all valid bits; the pipeline is empty afterward.
module givens_rotation_unit_core #(
	parameter int DATA_WIDTH     = gru_pkg::DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = gru_pkg::COEF_FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	gru_req_if.sink   req,
	gru_rsp_if.source rsp
);
	localparam int DW  = DATA_WIDTH;
	localparam int F   = COEF_FRAC_BITS;
	localparam int CW  = F + 2;
	localparam int QW  = F + 1;
	localparam int RW1 = DW + F + 1;
	localparam int UW  = 2 * F + 2;
	localparam int RW2 = 2 * F + 1;
	localparam int PW  = DW + CW;
	localparam int SW  = PW + 1;
	localparam int IU  = F + 2;
	localparam int IK  = 2 * F + 4;
	localparam int IM  = 3 * F + 6;
	localparam int IP  = 3 * F + 7;
	localparam int IO  = 3 * F + 8;
	localparam int NS  = 3 * F + 9;

	localparam logic signed [SW-1:0] MAXV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (F - 1);
	localparam logic signed [CW-1:0] ONE  = {{(CW-1){1'b0}}, 1'b1} << F;

	typedef struct packed {
		logic          req_type;
		logic [DW-1:0] x;
		logic [DW-1:0] y;
		logic [CW-1:0] c_in;
		logic [CW-1:0] s_in;
		logic          yz;
		logic          bgt;
		logic          neg;
		logic [QW-1:0] t;
	} sb_t;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	sb_t           sb_q [0:IM];

	logic [RW1-1:0] rem1 [0:QW];
	logic [DW-1:0]  dvs1 [0:QW];
	logic [QW-1:0]  quo1 [0:QW];
	logic [UW-1:0]  rem_sq [0:QW];
	logic [UW-1:0]  res_sq [0:QW];
	logic [RW2-1:0] rem2 [0:QW];
	logic [QW-1:0]  dvs2 [0:QW];
	logic [QW-1:0]  quo2 [0:QW];

	logic [DW-1:0]  a_abs, b_abs, big, lesser;
	logic           bgt;
	logic [RW1-1:0] num1;
	logic [UW-1:0]  tt, u_val;
	logic [QW-1:0]  r_val;
	logic [RW2-1:0] num2;
	logic [UW-1:0]  tk, mr;
	logic [QW-1:0]  m_val;
	logic [CW-1:0]  kc, mc, c_nxt, s_nxt;

	logic signed [CW-1:0] c_s1, s_s1, c_s2, s_s2;
	logic signed [PW-1:0] cx_s2, sy_s2, cy_s2, sx_s2;
	logic signed [SW-1:0] sum_x, sum_y, rx, ry;
	logic                 sat_x, sat_y;
	logic signed [DW-1:0] x_s3, y_s3;
	logic signed [CW-1:0] c_s3, s_s3;
	logic                 sat_s3;

	assign en[NS-1] = !vld_q[NS-1] || rsp.ready;
	for (genvar i = 0; i < NS - 1; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end
	assign req.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= req.valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign a_abs  = req.x_in[DW-1] ? (~req.x_in + 1'b1) : req.x_in;
	assign b_abs  = req.y_in[DW-1] ? (~req.y_in + 1'b1) : req.y_in;
	assign bgt    = b_abs > a_abs;
	assign big    = bgt ? b_abs : a_abs;
	assign lesser = bgt ? a_abs : b_abs;
	assign num1   = {1'b0, lesser, {F{1'b0}}} + {{(F+2){1'b0}}, big[DW-1:1]};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sb_q[0].req_type <= req.req_type;
			sb_q[0].x        <= req.x_in;
			sb_q[0].y        <= req.y_in;
			sb_q[0].c_in     <= req.cos_in;
			sb_q[0].s_in     <= req.sin_in;
			sb_q[0].yz       <= req.y_in == '0;
			sb_q[0].bgt      <= bgt;
			sb_q[0].neg      <= req.x_in[DW-1] != req.y_in[DW-1];
			sb_q[0].t        <= '0;
			rem1[0]          <= num1;
			dvs1[0]          <= big;
			quo1[0]          <= '0;
		end
	end

	for (genvar i = 1; i <= IM; i++) begin : g_sb
		if (i == IU) begin : g_t
			always_ff @(posedge clk) begin
				if (en[i]) begin
					sb_q[i] <= sb_t'({sb_q[i-1][$bits(sb_t)-1:QW], quo1[QW]});
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en[i]) begin
					sb_q[i] <= sb_q[i-1];
				end
			end
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_div1
		gru_div_cell #(.RW(RW1), .DVW(DW), .QW(QW), .SH(F - g)) u_div1 (
			.clk   (clk),
			.en    (en[1+g]),
			.rem_i (rem1[g]),
			.dvs_i (dvs1[g]),
			.quo_i (quo1[g]),
			.rem_o (rem1[g+1]),
			.dvs_o (dvs1[g+1]),
			.quo_o (quo1[g+1])
		);
	end

	assign tt    = UW'(quo1[QW]) * UW'(quo1[QW]);
	assign u_val = tt + ({{(UW-1){1'b0}}, 1'b1} << (2 * F));

	always_ff @(posedge clk) begin
		if (en[IU]) begin
			rem_sq[0] <= u_val;
			res_sq[0] <= '0;
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_sqrt
		gru_sqrt_cell #(.UW(UW), .J(F - g)) u_sqrt (
			.clk   (clk),
			.en    (en[IU+1+g]),
			.rem_i (rem_sq[g]),
			.res_i (res_sq[g]),
			.rem_o (rem_sq[g+1]),
			.res_o (res_sq[g+1])
		);
	end

	assign r_val = res_sq[QW][QW-1:0];
	assign num2  = ({{(RW2-1){1'b0}}, 1'b1} << (2 * F)) + {{(F+1){1'b0}}, r_val[QW-1:1]};

	always_ff @(posedge clk) begin
		if (en[IK]) begin
			rem2[0] <= num2;
			dvs2[0] <= r_val;
			quo2[0] <= '0;
		end
	end

	for (genvar g = 0; g < QW; g++) begin : g_div2
		gru_div_cell #(.RW(RW2), .DVW(QW), .QW(QW), .SH(F - g)) u_div2 (
			.clk   (clk),
			.en    (en[IK+1+g]),
			.rem_i (rem2[g]),
			.dvs_i (dvs2[g]),
			.quo_i (quo2[g]),
			.rem_o (rem2[g+1]),
			.dvs_o (dvs2[g+1]),
			.quo_o (quo2[g+1])
		);
	end

	assign tk    = UW'(sb_q[IM-1].t) * UW'(quo2[QW]);
	assign mr    = tk + ({{(UW-1){1'b0}}, 1'b1} << (F - 1));
	assign m_val = mr[2*F:F];
	assign kc    = {1'b0, quo2[QW]};
	assign mc    = sb_q[IM-1].neg ? (~{1'b0, m_val} + 1'b1) : {1'b0, m_val};

	always_comb begin
		if (sb_q[IM-1].req_type) begin
			c_nxt = sb_q[IM-1].c_in;
			s_nxt = sb_q[IM-1].s_in;
		end else if (sb_q[IM-1].yz) begin
			c_nxt = ONE;
			s_nxt = '0;
		end else if (sb_q[IM-1].bgt) begin
			c_nxt = mc;
			s_nxt = kc;
		end else begin
			c_nxt = kc;
			s_nxt = mc;
		end
	end

	always_ff @(posedge clk) begin
		if (en[IM]) begin
			c_s1 <= c_nxt;
			s_s1 <= s_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en[IP]) begin
			cx_s2 <= PW'(c_s1) * PW'($signed(sb_q[IM].x));
			sy_s2 <= PW'(s_s1) * PW'($signed(sb_q[IM].y));
			cy_s2 <= PW'(c_s1) * PW'($signed(sb_q[IM].y));
			sx_s2 <= PW'(s_s1) * PW'($signed(sb_q[IM].x));
			c_s2  <= c_s1;
			s_s2  <= s_s1;
		end
	end

	assign sum_x = SW'(cx_s2) + SW'(sy_s2);
	assign sum_y = SW'(cy_s2) - SW'(sx_s2);
	assign rx    = (sum_x + HALF) >>> F;
	assign ry    = (sum_y + HALF) >>> F;
	assign sat_x = (rx > MAXV) || (rx < MINV);
	assign sat_y = (ry > MAXV) || (ry < MINV);

	always_ff @(posedge clk) begin
		if (en[IO]) begin
			x_s3   <= (rx > MAXV) ? MAXV[DW-1:0] : ((rx < MINV) ? MINV[DW-1:0] : rx[DW-1:0]);
			y_s3   <= (ry > MAXV) ? MAXV[DW-1:0] : ((ry < MINV) ? MINV[DW-1:0] : ry[DW-1:0]);
			c_s3   <= c_s2;
			s_s3   <= s_s2;
			sat_s3 <= sat_x || sat_y;
		end
	end

	assign rsp.valid     = vld_q[NS-1];
	assign rsp.x_out     = x_s3;
	assign rsp.y_out     = y_s3;
	assign rsp.cos_out   = c_s3;
	assign rsp.sin_out   = s_s3;
	assign rsp.saturated = sat_s3;
endmodule

// File: hw/rtl/gru_checker.sv
module gru_checker #(
	parameter int DW = gru_pkg::DATA_WIDTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic signed [DW-1:0] rsp_x,
	input logic signed [DW-1:0] rsp_y,
	input logic                 rsp_sat
);
	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y))
		else $error("response changed while stalled");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_sat |->
		(rsp_x == MAXV || rsp_x == MINV || rsp_y == MAXV || rsp_y == MINV))
		else $error("saturation flag without clipped result");
endmodule

bind givens_rotation_unit_core gru_checker #(.DW(DATA_WIDTH)) u_gru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_x     (rsp.x_out),
	.rsp_y     (rsp.y_out),
	.rsp_sat   (rsp.saturated)
);
